// ===== rtl/core/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg: shared types, constants and functions
// Frame layout, CRC-8 constants and scaling constants for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Frame positions
    localparam logic [2:0] STATUS_INDEX    = 3'd0;
    localparam logic [2:0] FIRST_DATA_INDEX = 3'd1;
    localparam logic [2:0] LAST_DATA_INDEX = 3'd5;

    // Status bits
    localparam int BUSY_BIT = 7;
    localparam int CAL_BIT  = 3;

    // Widths
    localparam int RAW_W   = 20;
    localparam int DATA_W  = 2 * RAW_W;
    localparam int HUM_W   = 14;
    localparam int TEMP_W  = 15;

    // Scaling: value * scale / 2^20
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

    // Completed frame handed from the frame tracker
    typedef struct packed {
        logic             emit;
        logic [RAW_W-1:0] hum_raw;
        logic [RAW_W-1:0] temp_meas;
        logic             crc_ok;
        logic [7:0]       status;
    } frame_result_t;

    // One byte of CRC-8, eight bit steps
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htfd_frame.sv =====
// ----------------------------------------------------------------------------
// htfd_frame: frame tracker
// Keeps the byte position, running CRC, status byte and data shift register,
// and presents the completed frame when the CRC byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_frame
    import htfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output frame_result_t      result
);

    logic [2:0]        byte_index_reg, byte_index_next;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        status_reg, status_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [2:0]        pos;

    // Position of this word; frame_start forces the status slot
    assign pos = frame_start ? STATUS_INDEX : byte_index_reg;

    // Next state and frame result
    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        status_next     = status_reg;
        data_next       = data_reg;

        result.emit      = 1'b0;
        result.hum_raw   = data_reg[DATA_W-1:RAW_W];
        result.temp_meas = data_reg[RAW_W-1:0];
        result.crc_ok    = (crc_reg == rx_byte);
        result.status    = status_reg;

        if (pos == STATUS_INDEX)
        begin
            status_next     = rx_byte;
            data_next       = '0;
            crc_next        = crc8_update(CRC_INIT, rx_byte);
            byte_index_next = FIRST_DATA_INDEX;
        end
        else if (pos <= LAST_DATA_INDEX)
        begin
            data_next       = {data_reg[DATA_W-9:0], rx_byte};
            crc_next        = crc8_update(crc_reg, rx_byte);
            byte_index_next = pos + 3'd1;
        end
        else
        begin
            // CRC byte (an index of 7 is treated the same)
            result.emit     = 1'b1;
            byte_index_next = STATUS_INDEX;
            crc_next        = CRC_INIT;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= STATUS_INDEX;
            crc_reg        <= CRC_INIT;
            status_reg     <= '0;
            data_reg       <= '0;
        end
        else if (step)
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            status_reg     <= status_next;
            data_reg       <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/htfd_scale.sv =====
// ----------------------------------------------------------------------------
// htfd_scale: reading scaler
// Converts raw 20-bit readings to hundredths of a percent and of a degree.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_scale
    import htfd_pkg::*;
(
    input  wire logic [RAW_W-1:0]         hum_raw,
    input  wire logic [RAW_W-1:0]         temp_meas,
    output logic      [HUM_W-1:0]         hum_centi,
    output logic signed [TEMP_W-1:0]      temp_centi
);

    logic [RAW_W+HUM_W-1:0]  hum_prod;
    logic [RAW_W+TEMP_W-1:0] temp_prod;
    logic [TEMP_W-1:0]       temp_unsigned;

    // One constant multiply per reading, then drop 20 fraction bits
    assign hum_prod      = {{HUM_W{1'b0}}, hum_raw} * {{RAW_W{1'b0}}, HUM_SCALE};
    assign temp_prod     = {{TEMP_W{1'b0}}, temp_meas} * {{RAW_W{1'b0}}, TEMP_SCALE};
    assign hum_centi     = hum_prod[RAW_W+HUM_W-1:RAW_W];
    assign temp_unsigned = temp_prod[RAW_W+TEMP_W-1:RAW_W];

    // Offset; range -5000..14999 fits 15-bit two's complement
    assign temp_centi = $signed(temp_unsigned - TEMP_OFFSET);

endmodule

`default_nettype wire

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: sensor measurement frame decoder
// Checks CRC-8 and decodes raw and scaled humidity/temperature per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, unless the input side stalls, and emits one
// result word on the seventh byte of each frame (status, five data bytes, CRC).
// A result is registered after its CRC byte is accepted: the byte lands in the
// input register when accepted, and the frame tracker, CRC and constant-multiply
// scaling load the result register from it once the output can take a result.
// The input side keeps accepting while a result waits to be taken; it stalls
// only when a CRC byte is held behind a stalled result.
// A frame_start byte always restarts the frame and drops any partial one.
`default_nettype none

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [RAW_W-1:0]        humidity_raw,
    output logic [RAW_W-1:0]        temperature_raw,
    output logic [HUM_W-1:0]        humidity_centi,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic                    crc_ok,
    output logic                    busy_flag,
    output logic                    calibrated_flag,
    output logic [7:0]              status_byte
);

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               s1_start_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_ready;
    logic               s1_move;
    logic               in_accept;
    frame_result_t      frame_res;
    logic [HUM_W-1:0]   hum_centi;
    logic signed [TEMP_W-1:0] temp_centi;

    logic [RAW_W-1:0]   hum_raw_reg;
    logic [RAW_W-1:0]   temp_meas_reg;
    logic [HUM_W-1:0]   hum_centi_reg;
    logic [TEMP_W-1:0]  temp_centi_reg;
    logic               crc_ok_reg;
    logic [7:0]         status_reg;

    // Handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && (!frame_res.emit || out_ready);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_ready ? (s1_move && frame_res.emit) : out_valid_reg;

    // Frame tracker
    htfd_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_move),
        .rx_byte     (s1_byte_reg),
        .frame_start (s1_start_reg),
        .result      (frame_res)
    );

    // Scaling
    htfd_scale u_scale
    (
        .hum_raw    (frame_res.hum_raw),
        .temp_meas  (frame_res.temp_meas),
        .hum_centi  (hum_centi),
        .temp_centi (temp_centi)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_ready && s1_move && frame_res.emit)
        begin
            hum_raw_reg    <= frame_res.hum_raw;
            temp_meas_reg  <= frame_res.temp_meas;
            hum_centi_reg  <= hum_centi;
            temp_centi_reg <= temp_centi;
            crc_ok_reg     <= frame_res.crc_ok;
            status_reg     <= frame_res.status;
        end
    end

    assign out_valid         = out_valid_reg;
    assign humidity_raw      = hum_raw_reg;
    assign temperature_raw   = temp_meas_reg;
    assign humidity_centi    = hum_centi_reg;
    assign temperature_centi = $signed(temp_centi_reg);
    assign crc_ok            = crc_ok_reg;
    assign busy_flag         = status_reg[BUSY_BIT];
    assign calibrated_flag   = status_reg[CAL_BIT];
    assign status_byte       = status_reg;

    // Checks
    a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a word in the input register");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && frame_res.emit && out_valid_reg && out_stall))
        else $error("input stalled without a blocked CRC word");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hum_centi_reg <= 14'd9999))
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(temp_centi_reg) >= -15'sd5000))
        else $error("temperature below range");

endmodule

`default_nettype wire
